>>> design/setf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setf_pkg
// shared types and constants for the scan-line edge table fill block
// ----------------------------------------------------------------------------
package setf_pkg;

    localparam int ROWS_DEFAULT = 512;
    localparam int SPAN_W       = 9;
    localparam int FRAC_W       = 16;
    localparam int X_W          = SPAN_W + FRAC_W;
    localparam int SLOPE_W      = X_W + 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SPAN_W-1:0] LEFT_RESET  = 9'd511;
    localparam logic [SPAN_W-1:0] RIGHT_RESET = 9'd0;

    localparam logic ACT_EDGE  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // classified command passed from the front to the back
    typedef struct packed {
        logic              is_query;
        logic              clear;
        logic [SPAN_W-1:0] lo_span;
        logic [SPAN_W-1:0] lo_row;
        logic [SPAN_W-1:0] hi_row;
        logic              neg;
        logic [SPAN_W-1:0] mag;
        logic [SPAN_W-1:0] drow;
        logic [SPAN_W-1:0] query_row;
    } setf_cmd_t;

    // one table row: least and greatest crossing
    typedef struct packed {
        logic [SPAN_W-1:0] left;
        logic [SPAN_W-1:0] right;
    } setf_entry_t;

endpackage

>>> design/setf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setf_front
// accepts items, orders edge endpoints and queues commands for the back part
// ----------------------------------------------------------------------------
module setf_front
    import setf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              hold,
    input  logic              action,
    input  logic              clear_first,
    input  logic [SPAN_W-1:0] edge_a_span,
    input  logic [SPAN_W-1:0] edge_a_row,
    input  logic [SPAN_W-1:0] edge_b_span,
    input  logic [SPAN_W-1:0] edge_b_row,
    input  logic [SPAN_W-1:0] query_row,
    output logic              busy,
    output logic              cmd_valid,
    output setf_cmd_t         cmd,
    input  logic              cmd_pop
);

    setf_cmd_t         queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              full;
    logic              push;
    logic              swap;
    setf_cmd_t         new_cmd;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign busy      = full || hold;
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // endpoint ordering and slope operands
    always_comb
    begin
        swap              = (edge_b_row < edge_a_row);
        new_cmd.is_query  = (action == ACT_QUERY);
        new_cmd.clear     = clear_first;
        new_cmd.lo_span   = swap ? edge_b_span : edge_a_span;
        new_cmd.lo_row    = swap ? edge_b_row  : edge_a_row;
        new_cmd.hi_row    = swap ? edge_a_row  : edge_b_row;
        new_cmd.neg       = swap ? (edge_a_span < edge_b_span) : (edge_b_span < edge_a_span);
        new_cmd.drow      = new_cmd.hi_row - new_cmd.lo_row;
        new_cmd.query_row = query_row;
        if (swap)
        begin
            new_cmd.mag = new_cmd.neg ? (edge_b_span - edge_a_span) : (edge_a_span - edge_b_span);
        end
        else
        begin
            new_cmd.mag = new_cmd.neg ? (edge_a_span - edge_b_span) : (edge_b_span - edge_a_span);
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> design/setf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setf_div
// restoring divider for the slope magnitude, one quotient bit per cycle
// ----------------------------------------------------------------------------
module setf_div
    import setf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SPAN_W-1:0] mag,
    input  logic [SPAN_W-1:0] divisor,
    output logic              done,
    output logic [X_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(X_W);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SPAN_W-1:0] rem_reg;
    logic [X_W-1:0]    dvd_reg;
    logic [SPAN_W-1:0] divisor_reg;
    logic [SPAN_W:0]   shifted;
    logic [SPAN_W+1:0] diff;
    logic              ge;

    assign shifted  = {rem_reg, dvd_reg[X_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, divisor_reg};
    assign ge       = !diff[SPAN_W+1];
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(X_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg     <= {mag, {FRAC_W{1'b0}}};
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[SPAN_W-1:0] : shifted[SPAN_W-1:0];
            dvd_reg <= {dvd_reg[X_W-2:0], ge};
        end
    end

endmodule

>>> design/setf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setf_back
// runs commands: table clearing, slope division, row walk and row queries
// ----------------------------------------------------------------------------
module setf_back
    import setf_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  setf_cmd_t         cmd,
    output logic              cmd_pop,
    output logic              hold,
    output logic              done,
    output logic [SPAN_W-1:0] span_left,
    output logic [SPAN_W-1:0] span_right,
    output logic              span_valid
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = ((RW > SPAN_W) ? RW : SPAN_W) + 1;
    localparam logic [CW-1:0] ROWS_C   = CW'(ROWS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_QREAD = 3'd7;

    setf_entry_t mem [ROWS];

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [RW-1:0]              ctr_reg;
    logic [RW-1:0]              ctr_next;
    setf_cmd_t                  cur_reg;
    setf_cmd_t                  cur_next;
    logic [SPAN_W-1:0]          row_reg;
    logic [SPAN_W-1:0]          row_next;
    logic [X_W-1:0]             x_reg;
    logic [X_W-1:0]             x_next;
    logic signed [SLOPE_W-1:0]  slope_reg;
    logic signed [SLOPE_W-1:0]  slope_next;
    logic                       p_valid_reg;
    logic                       p_valid_next;
    logic [RW-1:0]              p_row_reg;
    logic [RW-1:0]              p_row_next;
    logic [X_W-1:0]             p_x_reg;
    logic [X_W-1:0]             p_x_next;
    setf_entry_t                rd_data_reg;
    logic                       done_reg;
    logic                       done_next;
    logic [SPAN_W-1:0]          left_reg;
    logic [SPAN_W-1:0]          left_next;
    logic [SPAN_W-1:0]          right_reg;
    logic [SPAN_W-1:0]          right_next;
    logic                       valid_reg;
    logic                       valid_next;

    logic                       re;
    logic [RW-1:0]              ra;
    logic                       we;
    logic [RW-1:0]              wa;
    setf_entry_t                wd;
    setf_entry_t                merged;
    logic                       div_start;
    logic                       div_done;
    logic [X_W-1:0]             div_quo;
    logic                       row_in;
    logic                       query_in;
    logic [SPAN_W-1:0]          whole;
    logic                       upd_left;
    logic                       upd_right;

    setf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (cur_reg.mag),
        .divisor  (cur_reg.drow),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign hold       = (state_reg == S_INIT);
    assign cmd_pop    = (state_reg == S_IDLE) && cmd_valid;
    assign done       = done_reg;
    assign span_left  = left_reg;
    assign span_right = right_reg;
    assign span_valid = valid_reg;

    assign row_in   = ({{(CW - SPAN_W){1'b0}}, row_reg} < ROWS_C);
    assign query_in = ({{(CW - SPAN_W){1'b0}}, cmd.query_row} < ROWS_C);

    // fold the crossing into the row that was read last cycle
    always_comb
    begin
        whole     = p_x_reg[X_W-1:FRAC_W];
        upd_left  = (whole < rd_data_reg.left);
        upd_right = (whole > rd_data_reg.right) ||
                    ((whole == rd_data_reg.right) && (p_x_reg[FRAC_W-1:0] != '0));
        merged.left  = upd_left  ? whole : rd_data_reg.left;
        merged.right = upd_right ? whole : rd_data_reg.right;
    end

    always_comb
    begin
        state_next   = state_reg;
        ctr_next     = ctr_reg;
        cur_next     = cur_reg;
        row_next     = row_reg;
        x_next       = x_reg;
        slope_next   = slope_reg;
        p_valid_next = 1'b0;
        p_row_next   = p_row_reg;
        p_x_next     = p_x_reg;
        done_next    = 1'b0;
        left_next    = left_reg;
        right_next   = right_reg;
        valid_next   = valid_reg;
        re           = 1'b0;
        ra           = '0;
        div_start    = 1'b0;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                if (ctr_reg == LAST_ROW)
                begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_PREP;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next = cmd;
                    row_next = cmd.lo_row;
                    x_next   = {cmd.lo_span, {FRAC_W{1'b0}}};
                    ctr_next = '0;
                    if (cmd.is_query)
                    begin
                        if (query_in)
                        begin
                            re         = 1'b1;
                            ra         = RW'(cmd.query_row);
                            state_next = S_QREAD;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            left_next  = LEFT_RESET;
                            right_next = RIGHT_RESET;
                            valid_next = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next = cmd.clear ? S_CLEAR : S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                if (cur_reg.drow == '0)
                begin
                    slope_next = '0;
                    state_next = S_WALK;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    slope_next = cur_reg.neg ? -$signed({1'b0, div_quo})
                                             : $signed({1'b0, div_quo});
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (row_in)
                begin
                    re           = 1'b1;
                    ra           = RW'(row_reg);
                    p_valid_next = 1'b1;
                    p_row_next   = RW'(row_reg);
                    p_x_next     = x_reg;
                end
                x_next   = X_W'($signed({1'b0, x_reg}) + slope_reg);
                row_next = row_reg + 1'b1;
                if (!row_in || (row_reg == cur_reg.hi_row))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            S_QREAD:
            begin
                done_next  = 1'b1;
                left_next  = rd_data_reg.left;
                right_next = rd_data_reg.right;
                valid_next = (rd_data_reg.left <= rd_data_reg.right);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // write port: row update has priority, else the clearing sweep
    always_comb
    begin
        we = 1'b0;
        wa = ctr_reg;
        wd = merged;
        if (p_valid_reg)
        begin
            we = 1'b1;
            wa = p_row_reg;
            wd = merged;
        end
        else if ((state_reg == S_INIT) || (state_reg == S_CLEAR))
        begin
            we       = 1'b1;
            wa       = ctr_reg;
            wd.left  = LEFT_RESET;
            wd.right = RIGHT_RESET;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            ctr_reg     <= '0;
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ctr_reg     <= ctr_next;
            p_valid_reg <= p_valid_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        row_reg   <= row_next;
        x_reg     <= x_next;
        slope_reg <= slope_next;
        p_row_reg <= p_row_next;
        p_x_reg   <= p_x_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        valid_reg <= valid_next;
    end

endmodule

>>> design/scanline_edge_table_fill_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_edge_table_fill_top
// scan-line polygon fill over per-row least and greatest crossing tables
// ----------------------------------------------------------------------------
// An item is taken at a clock edge with start high and busy low. action
// selects an edge (folded into both tables, no result) or a row query (one
// result). A result shows on span_left, span_right and span_valid for one
// cycle with done high; the receiver takes every result as it comes.
// Items enter a two-entry command queue, so busy rises when it is full or
// while the table is cleared after reset. A query that leaves the queue
// reads its row from the table, and done rises with the read result; for a
// row past the table, done rises without a read.
// An edge first takes its slope from the bit-serial divider (25 quotient
// bits, then its done strobe), then one table row per cycle through the
// read-modify-write pipeline on the single table memory. A flat edge skips
// the divider.
// With clear_first set, a clearing sweep over all ROWS rows runs first.
// After reset the same sweep clears the table, with busy held high; the
// block then takes items.
// ----------------------------------------------------------------------------
module scanline_edge_table_fill_top
    import setf_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic              clear_first,
    input  logic [SPAN_W-1:0] edge_a_span,
    input  logic [SPAN_W-1:0] edge_a_row,
    input  logic [SPAN_W-1:0] edge_b_span,
    input  logic [SPAN_W-1:0] edge_b_row,
    input  logic [SPAN_W-1:0] query_row,
    output logic              done,
    output logic [SPAN_W-1:0] span_left,
    output logic [SPAN_W-1:0] span_right,
    output logic              span_valid
);

    logic      hold;
    logic      cmd_valid;
    logic      cmd_pop;
    setf_cmd_t cmd;

    setf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .hold        (hold),
        .action      (action),
        .clear_first (clear_first),
        .edge_a_span (edge_a_span),
        .edge_a_row  (edge_a_row),
        .edge_b_span (edge_b_span),
        .edge_b_row  (edge_b_row),
        .query_row   (query_row),
        .busy        (busy),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    setf_back #(
        .ROWS (ROWS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .hold       (hold),
        .done       (done),
        .span_left  (span_left),
        .span_right (span_right),
        .span_valid (span_valid)
    );

endmodule
